// File: rtl/pvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pvm_pkg;

  localparam int unsigned W_BITS   = 24;
  localparam int unsigned FRAC     = 28;
  localparam int unsigned Q_W      = FRAC + 1;
  localparam int unsigned DIV_W    = (W_BITS > Q_W) ? W_BITS : Q_W;
  localparam int unsigned DIV_STEP = 2;
  localparam int unsigned DIV_NST  = FRAC / DIV_STEP;
  localparam int unsigned P_W      = FRAC + 4;
  localparam int unsigned K_W      = 27;
  localparam int unsigned K_FRAC   = 24;
  localparam int unsigned KP_W     = K_W + Q_W;
  localparam int unsigned PN_W     = KP_W + 1;
  localparam int unsigned ETA_SH   = 36;
  localparam int unsigned E_W      = PN_W - ETA_SH;
  localparam int unsigned ETA_W    = 17;
  localparam int unsigned T2_W     = FRAC + 2;
  localparam int unsigned T4_W     = FRAC + 4;
  localparam int unsigned T5_W     = FRAC + 5;
  localparam int unsigned POLY_ST  = 5;
  localparam int unsigned ETA_ST   = 5;
  localparam int unsigned PIPE_LAT = 2 * (DIV_NST + 1) + POLY_ST + 3 * FRAC + ETA_ST + 2;

  localparam logic [Q_W-1:0]   ONE_Q   = {1'b1, {FRAC{1'b0}}};
  localparam logic [ETA_W-1:0] ETA_ONE = {1'b1, {(ETA_W-1){1'b0}}};

  function automatic logic [K_W-1:0] kq(input longint unsigned n);
    return K_W'(((n << K_FRAC) + 64'd50000) / 64'd100000);
  endfunction

  localparam logic [K_W-1:0] KP1 = kq(269269);
  localparam logic [K_W-1:0] KP2 = kq(242843);
  localparam logic [K_W-1:0] KP3 = kq(447163);
  localparam logic [K_W-1:0] KP4 = kq(7842);
  localparam logic [K_W-1:0] KE1 = kq(136603);
  localparam logic [K_W-1:0] KE2 = kq(47719);
  localparam logic [K_W-1:0] KE3 = kq(11116);

  typedef struct packed {
    logic [W_BITS-1:0] lorentz_width;
    logic [W_BITS-1:0] gauss_width;
  } pvm_in_t;

  typedef struct packed {
    logic [ETA_W-1:0]  mix_factor;
    logic [W_BITS-1:0] combined_width;
    logic              zero_width_error;
  } pvm_out_t;

  typedef struct packed {
    logic              err;
    logic              lmax;
    logic [W_BITS-1:0] m;
    logic [Q_W-1:0]    x;
    logic [P_W-1:0]    p;
    logic [Q_W-1:0]    s;
    logic [W_BITS-1:0] f;
  } pvm_side_t;

  function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] pr;
    pr = (2*Q_W)'(a) * (2*Q_W)'(b);
    return pr[FRAC +: Q_W];
  endfunction

  function automatic logic [P_W-1:0] kmul(input logic [K_W-1:0] k, input logic [Q_W-1:0] t);
    logic [KP_W-1:0] pr;
    pr = KP_W'(k) * KP_W'(t);
    return pr[K_FRAC +: P_W];
  endfunction

endpackage

`default_nettype wire

// File: rtl/pseudo_voigt_mixing_parameter.sv
`timescale 1ns / 1ps
`default_nettype none

// Pseudo-Voigt mixing parameter, fully pipelined.
// A transaction is accepted at each rising edge where start_i is high and
// busy_o is low. busy_o is always low, so one width pair can enter every cycle.
// req_i carries the Lorentzian and Gaussian widths in unsigned Q4.20.
// res_o carries eta in Q1.16, the combined width in Q4.20 (saturated) and
// the zero width flag, marked by done_o for exactly one cycle.
// Throughput is one result per cycle. The latency is set by two 15 stage
// ratio dividers (two quotient bits per stage after the first, which yields
// one), the 84 stage fifth root search (three multiplier stages for each
// of 28 result bits), and the polynomial and eta multiplier stages.
// Reset empties the pipeline; items in flight are dropped and no strobe
// follows. Results cannot be held off by the receiver.
module pseudo_voigt_mixing_parameter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  pvm_pkg::pvm_in_t  req_i,
  output logic              done_o,
  output pvm_pkg::pvm_out_t res_o
);
  import pvm_pkg::*;

  logic              v0_q;
  pvm_side_t         s0_d, s0_q;
  logic [W_BITS-1:0] n0_d, n0_q;

  logic              d1_v;
  pvm_side_t         d1_s, d1_sx;
  logic [Q_W-1:0]    d1_q;

  logic              pl_v;
  pvm_side_t         pl_s;
  logic              rt_v;
  pvm_side_t         rt_s;

  logic                  vf_q;
  pvm_side_t             sf_d, sf_q;
  logic [W_BITS+Q_W-1:0] fprod;
  logic [W_BITS:0]       fsh;

  logic              d2_v;
  pvm_side_t         d2_s;
  logic [Q_W-1:0]    d2_q;

  assign busy_o = 1'b0;

  always_comb begin
    logic lmax;
    lmax      = req_i.lorentz_width > req_i.gauss_width;
    s0_d      = '0;
    s0_d.err  = (req_i.lorentz_width == '0) && (req_i.gauss_width == '0);
    s0_d.lmax = lmax;
    s0_d.m    = lmax ? req_i.lorentz_width : req_i.gauss_width;
    n0_d      = lmax ? req_i.gauss_width : req_i.lorentz_width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      vf_q <= rt_v;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    n0_q <= n0_d;
    sf_q <= sf_d;
  end

  pvm_div u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .side_i  (s0_q),
    .num_i   (DIV_W'(n0_q)),
    .den_i   (DIV_W'(s0_q.m)),
    .valid_o (d1_v),
    .side_o  (d1_s),
    .quo_o   (d1_q)
  );

  always_comb begin
    d1_sx   = d1_s;
    d1_sx.x = d1_q;
  end

  pvm_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d1_v),
    .side_i  (d1_sx),
    .valid_o (pl_v),
    .side_o  (pl_s)
  );

  pvm_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pl_v),
    .side_i  (pl_s),
    .valid_o (rt_v),
    .side_o  (rt_s)
  );

  always_comb begin
    fprod = (W_BITS+Q_W)'(rt_s.m) * (W_BITS+Q_W)'(rt_s.s);
    fsh   = fprod[FRAC +: W_BITS+1];
    sf_d  = rt_s;
    if (fsh > {1'b0, {W_BITS{1'b1}}}) begin
      sf_d.f = {W_BITS{1'b1}};
    end else begin
      sf_d.f = fsh[W_BITS-1:0];
    end
  end

  pvm_div u_div_eta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vf_q),
    .side_i  (sf_q),
    .num_i   (DIV_W'(sf_q.lmax ? ONE_Q : sf_q.x)),
    .den_i   (DIV_W'(sf_q.s)),
    .valid_o (d2_v),
    .side_o  (d2_s),
    .quo_o   (d2_q)
  );

  pvm_eta u_eta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d2_v),
    .side_i  (d2_s),
    .r_i     (d2_q),
    .valid_o (done_o),
    .res_o   (res_o)
  );

  ap_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##PIPE_LAT done_o)
    else $error("accepted transaction produced no result at the expected latency");

  ap_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##PIPE_LAT !done_o)
    else $error("result strobe without a matching transaction");

  ap_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.zero_width_error |->
      res_o.mix_factor == '0 && res_o.combined_width == '0)
    else $error("zero width result carries nonzero fields");

  ap_eta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.mix_factor <= ETA_ONE)
    else $error("mixing factor above one");

endmodule

`default_nettype wire

// File: rtl/pvm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pvm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  pvm_pkg::pvm_side_t          side_i,
  input  logic [pvm_pkg::DIV_W-1:0]   num_i,
  input  logic [pvm_pkg::DIV_W-1:0]   den_i,
  output logic                        valid_o,
  output pvm_pkg::pvm_side_t          side_o,
  output logic [pvm_pkg::Q_W-1:0]     quo_o
);
  import pvm_pkg::*;

  logic [DIV_NST:0] vld_q;
  pvm_side_t        side_q [DIV_NST+1];
  logic [DIV_W-1:0] den_q  [DIV_NST+1];
  logic [DIV_W-1:0] rem_q  [DIV_NST+1];
  logic [DIV_W-1:0] rem_d  [DIV_NST+1];
  logic [Q_W-1:0]   quo_q  [DIV_NST+1];
  logic [Q_W-1:0]   quo_d  [DIV_NST+1];

  always_comb begin
    logic [DIV_W:0] r;
    logic [Q_W-1:0] q;
    r = '0;
    q = '0;
    if (num_i >= den_i) begin
      rem_d[0] = num_i - den_i;
      quo_d[0] = Q_W'(1);
    end else begin
      rem_d[0] = num_i;
      quo_d[0] = '0;
    end
    for (int k = 1; k <= DIV_NST; k++) begin
      r = {1'b0, rem_q[k-1]};
      q = quo_q[k-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        r = {r[DIV_W-1:0], 1'b0};
        if (r >= {1'b0, den_q[k-1]}) begin
          r = r - {1'b0, den_q[k-1]};
          q = {q[Q_W-2:0], 1'b1};
        end else begin
          q = {q[Q_W-2:0], 1'b0};
        end
      end
      rem_d[k] = r[DIV_W-1:0];
      quo_d[k] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_NST-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    den_q[0]  <= den_i;
    rem_q[0]  <= rem_d[0];
    quo_q[0]  <= quo_d[0];
    for (int k = 1; k <= DIV_NST; k++) begin
      side_q[k] <= side_q[k-1];
      den_q[k]  <= den_q[k-1];
      rem_q[k]  <= rem_d[k];
      quo_q[k]  <= quo_d[k];
    end
  end

  assign valid_o = vld_q[DIV_NST];
  assign side_o  = side_q[DIV_NST];
  assign quo_o   = quo_q[DIV_NST];

endmodule

`default_nettype wire

// File: rtl/pvm_poly.sv
`timescale 1ns / 1ps
`default_nettype none

module pvm_poly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pvm_pkg::pvm_side_t side_i,
  output logic               valid_o,
  output pvm_pkg::pvm_side_t side_o
);
  import pvm_pkg::*;

  logic [POLY_ST-1:0] vld_q;
  pvm_side_t          s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [Q_W-1:0]     x2_1_q, x2_2_q, x3_2_q, x4_2_q, x5_3_q;
  logic [P_W-1:0]     k1_q, k2_q, k3_q, k4_q;
  logic [P_W-1:0]     k1_d, k2_d, k3_d, k4_d;
  logic [P_W-1:0]     sa_q, sb_q;
  pvm_side_t          s5_d;

  always_comb begin
    if (s2_q.lmax) begin
      k1_d = kmul(KP1, x4_2_q);
      k2_d = kmul(KP2, x3_2_q);
      k3_d = kmul(KP3, x2_2_q);
      k4_d = kmul(KP4, s2_q.x);
    end else begin
      k1_d = kmul(KP1, s2_q.x);
      k2_d = kmul(KP2, x2_2_q);
      k3_d = kmul(KP3, x3_2_q);
      k4_d = kmul(KP4, x4_2_q);
    end
    s5_d   = s4_q;
    s5_d.p = sa_q + sb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[POLY_ST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= side_i;
    x2_1_q <= qmul(side_i.x, side_i.x);
    s2_q   <= s1_q;
    x2_2_q <= x2_1_q;
    x3_2_q <= qmul(x2_1_q, s1_q.x);
    x4_2_q <= qmul(x2_1_q, x2_1_q);
    s3_q   <= s2_q;
    x5_3_q <= qmul(x4_2_q, s2_q.x);
    k1_q   <= k1_d;
    k2_q   <= k2_d;
    k3_q   <= k3_d;
    k4_q   <= k4_d;
    s4_q   <= s3_q;
    sa_q   <= P_W'(ONE_Q) + P_W'(x5_3_q) + k1_q;
    sb_q   <= k2_q + k3_q + k4_q;
    s5_q   <= s5_d;
  end

  assign valid_o = vld_q[POLY_ST-1];
  assign side_o  = s5_q;

endmodule

`default_nettype wire

// File: rtl/pvm_root.sv
`timescale 1ns / 1ps
`default_nettype none

module pvm_root (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pvm_pkg::pvm_side_t side_i,
  output logic               valid_o,
  output pvm_pkg::pvm_side_t side_o
);
  import pvm_pkg::*;

  logic [FRAC-1:0] va_q, vb_q, vc_q;
  pvm_side_t       sa_d [FRAC];
  pvm_side_t       sa_q [FRAC];
  pvm_side_t       sb_q [FRAC];
  pvm_side_t       sc_d [FRAC];
  pvm_side_t       sc_q [FRAC];
  logic [T2_W-1:0] t2_d [FRAC];
  logic [T2_W-1:0] t2_q [FRAC];
  logic [T4_W-1:0] t4_d [FRAC];
  logic [T4_W-1:0] t4_q [FRAC];

  // The leading one is always kept, since the sum never falls below one.
  always_comb begin
    logic [Q_W-1:0]      bitv;
    logic [Q_W-1:0]      ta, tc;
    logic [2*Q_W-1:0]    p2;
    logic [2*T2_W-1:0]   p4;
    logic [T4_W+Q_W-1:0] p5;
    logic [T5_W-1:0]     t5;
    bitv = '0;
    ta   = '0;
    tc   = '0;
    p2   = '0;
    p4   = '0;
    p5   = '0;
    t5   = '0;
    sa_d[0]   = side_i;
    sa_d[0].s = ONE_Q;
    for (int i = 1; i < FRAC; i++) begin
      sa_d[i] = sc_q[i-1];
    end
    for (int i = 0; i < FRAC; i++) begin
      bitv    = Q_W'(1) << (FRAC - 1 - i);
      ta      = sa_d[i].s | bitv;
      p2      = (2*Q_W)'(ta) * (2*Q_W)'(ta);
      t2_d[i] = p2[FRAC +: T2_W];
      p4      = (2*T2_W)'(t2_q[i]) * (2*T2_W)'(t2_q[i]);
      t4_d[i] = p4[FRAC +: T4_W];
      tc      = sb_q[i].s | bitv;
      p5      = (T4_W+Q_W)'(t4_q[i]) * (T4_W+Q_W)'(tc);
      t5      = p5[FRAC +: T5_W];
      sc_d[i] = sb_q[i];
      if (t5 <= T5_W'(sb_q[i].p)) begin
        sc_d[i].s = tc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
      vc_q <= '0;
    end else begin
      va_q <= {vc_q[FRAC-2:0], valid_i};
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAC; i++) begin
      sa_q[i] <= sa_d[i];
      t2_q[i] <= t2_d[i];
      sb_q[i] <= sa_q[i];
      t4_q[i] <= t4_d[i];
      sc_q[i] <= sc_d[i];
    end
  end

  assign valid_o = vc_q[FRAC-1];
  assign side_o  = sc_q[FRAC-1];

endmodule

`default_nettype wire

// File: rtl/pvm_eta.sv
`timescale 1ns / 1ps
`default_nettype none

module pvm_eta (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  pvm_pkg::pvm_side_t      side_i,
  input  logic [pvm_pkg::Q_W-1:0] r_i,
  output logic                    valid_o,
  output pvm_pkg::pvm_out_t       res_o
);
  import pvm_pkg::*;

  logic [ETA_ST-1:0] vld_q;
  pvm_side_t         s1_q, s2_q, s3_q, s4_q;
  logic [Q_W-1:0]    r1_q, r2_q, r3_q;
  logic [KP_W-1:0]   kr1_1_q, kr1_2_q, kr1_3_q, ng_2_q, ng_3_q, ng_4_q, kr3_3_q;
  logic [PN_W-1:0]   pos_q, diff;
  logic [E_W-1:0]    e;
  pvm_out_t          res_d, res_q;

  always_comb begin
    diff = pos_q - {1'b0, ng_4_q};
    if (pos_q > {1'b0, ng_4_q}) begin
      e = diff[ETA_SH +: E_W];
    end else begin
      e = '0;
    end
    if (s4_q.err) begin
      res_d.mix_factor       = '0;
      res_d.combined_width   = '0;
      res_d.zero_width_error = 1'b1;
    end else begin
      res_d.mix_factor       = (e > E_W'(ETA_ONE)) ? ETA_ONE : e[ETA_W-1:0];
      res_d.combined_width   = s4_q.f;
      res_d.zero_width_error = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ETA_ST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= side_i;
    r1_q    <= r_i;
    r2_q    <= qmul(r_i, r_i);
    kr1_1_q <= KP_W'(KE1) * KP_W'(r_i);
    s2_q    <= s1_q;
    r3_q    <= qmul(r2_q, r1_q);
    ng_2_q  <= KP_W'(KE2) * KP_W'(r2_q);
    kr1_2_q <= kr1_1_q;
    s3_q    <= s2_q;
    kr3_3_q <= KP_W'(KE3) * KP_W'(r3_q);
    kr1_3_q <= kr1_2_q;
    ng_3_q  <= ng_2_q;
    s4_q    <= s3_q;
    pos_q   <= PN_W'(kr1_3_q) + PN_W'(kr3_3_q);
    ng_4_q  <= ng_3_q;
    res_q   <= res_d;
  end

  assign valid_o = vld_q[ETA_ST-1];
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: sim/tb_pseudo_voigt_mixing_parameter.sv
`timescale 1ns / 1ps

module tb_pseudo_voigt_mixing_parameter;
  import pvm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  pvm_in_t  req_i;
  logic     done_o;
  pvm_out_t res_o;

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct;

  pseudo_voigt_mixing_parameter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic longint unsigned trunc_mul(input longint unsigned x,
                                                input longint unsigned y);
    return (x * y) >> FRAC;
  endfunction

  function automatic longint unsigned const_mul(input longint unsigned k,
                                                input longint unsigned t);
    return (k * t) >> K_FRAC;
  endfunction

  function automatic longint unsigned fifth_power(input longint unsigned t);
    longint unsigned t2;
    t2 = trunc_mul(t, t);
    return trunc_mul(trunc_mul(t2, t2), t);
  endfunction

  function automatic pvm_out_t predict_mix(input pvm_in_t req);
    pvm_out_t res;
    longint unsigned lw, gw, m, a, b, a2, a3, a4, b2, b3, b4, p, s, t, f, r, r2, r3;
    longint unsigned pos, neg, e;
    lw = 64'(req.lorentz_width);
    gw = 64'(req.gauss_width);
    res = '0;
    if (lw == 0 && gw == 0) begin
      res.zero_width_error = 1'b1;
      return res;
    end
    m = (lw > gw) ? lw : gw;
    a = (lw << FRAC) / m;
    b = (gw << FRAC) / m;
    a2 = trunc_mul(a, a);
    a3 = trunc_mul(a2, a);
    a4 = trunc_mul(a2, a2);
    b2 = trunc_mul(b, b);
    b3 = trunc_mul(b2, b);
    b4 = trunc_mul(b2, b2);
    p = trunc_mul(b4, b) + const_mul(KP1, trunc_mul(b4, a))
      + const_mul(KP2, trunc_mul(b3, a2)) + const_mul(KP3, trunc_mul(b2, a3))
      + const_mul(KP4, trunc_mul(b, a4)) + trunc_mul(a4, a);
    s = 0;
    for (int i = FRAC; i >= 0; i--) begin
      t = s | (64'd1 << i);
      if (fifth_power(t) <= p) s = t;
    end
    if (s < (64'd1 << FRAC)) s = 64'd1 << FRAC;
    f = (m * s) >> FRAC;
    if (f > (64'd1 << W_BITS) - 1) f = (64'd1 << W_BITS) - 1;
    r = (a << FRAC) / s;
    r2 = trunc_mul(r, r);
    r3 = trunc_mul(r2, r);
    pos = KE1 * r + KE3 * r3;
    neg = KE2 * r2;
    e = (pos > neg) ? ((pos - neg) >> ETA_SH) : 0;
    if (e > 65536) e = 65536;
    res.mix_factor = e[ETA_W-1:0];
    res.combined_width = f[W_BITS-1:0];
    return res;
  endfunction

  class mix_scoreboard;
    pvm_out_t pending_q[$];

    function void note_request(input pvm_in_t req);
      pending_q.push_back(predict_mix(req));
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction

    task check_result(input pvm_out_t got);
      pvm_out_t want;
      if (pending_q.size() == 0) begin
        $display("unexpected result at %0t", $time);
        error_count++;
        return;
      end
      want = pending_q.pop_front();
      if (got.mix_factor !== want.mix_factor)
        report_mismatch("mix_factor", 64'(got.mix_factor), 64'(want.mix_factor));
      if (got.combined_width !== want.combined_width)
        report_mismatch("combined_width", 64'(got.combined_width),
                        64'(want.combined_width));
      if (got.zero_width_error !== want.zero_width_error)
        report_mismatch("zero_width_error", 64'(got.zero_width_error),
                        64'(want.zero_width_error));
    endtask
  endclass

  mix_scoreboard widths_board;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) widths_board.check_result(res_o);
      if (start_i && !busy_o) widths_board.note_request(req_i);
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_widths(input logic [W_BITS-1:0] lw, input logic [W_BITS-1:0] gw);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i.lorentz_width <= lw;
    req_i.gauss_width <= gw;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic [W_BITS-1:0] random_width();
    case ($urandom_range(5))
      0: return W_BITS'($urandom_range(15));
      1: return {W_BITS{1'b1}} - W_BITS'($urandom_range(15));
      2: return W_BITS'($urandom) >> $urandom_range(W_BITS - 1);
      default: return W_BITS'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int unsigned count, input int unsigned idle_pct);
    logic [W_BITS-1:0] lw, gw;
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      lw = random_width();
      gw = ($urandom_range(7) == 0) ? lw : random_width();
      if ($urandom_range(19) == 0) lw = '0;
      else if ($urandom_range(19) == 0) gw = '0;
      send_widths(lw, gw);
    end
  endtask

  initial begin
    logic [W_BITS-1:0] top;
    widths_board = new();
    send_idle_pct = 0;
    top = {W_BITS{1'b1}};
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_widths('0, '0);
    send_widths(top, top);
    send_widths(top, '0);
    send_widths('0, top);
    send_widths(W_BITS'(1), '0);
    send_widths('0, W_BITS'(1));
    send_widths(W_BITS'(1), W_BITS'(1));
    send_widths(top, W_BITS'(1));
    send_widths(W_BITS'(1), top);
    send_widths(top, top >> 1);
    send_widths(top >> 1, top);
    send_widths(24'h100000, 24'h100000);
    send_widths(24'h555555, 24'haaaaaa);
    send_widths(24'haaaaaa, 24'h555555);
    send_widths(24'h800000, 24'h000001);
    start_i <= 1'b0;
    while (widths_board.outstanding() != 0) @(posedge clk_i);
    random_phase(550, 28);
    random_phase(550, 60);
    random_phase(550, 0);
    start_i <= 1'b0;
    while (widths_board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
